[design/nmsf_pkg.sv]
// Shared types, constants and decode functions for the noise moving-sum filter.
// No dependencies.
package nmsf_pkg;

    localparam int SMP_W  = 12;
    localparam int SUM_W  = 19;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 5;
    localparam int FREQ_W = 5;

    localparam logic [SMP_W-1:0]  MID        = 12'h800;
    localparam logic [SMP_W-1:0]  TOP        = 12'hFFF;
    localparam logic [CNT_W-1:0]  SEED_LIMIT = 5'd17;
    localparam logic [POS_W:0]    SHORT_WIN  = 8'd10;
    localparam logic [FREQ_W-1:0] FREQ_SHORT = 5'd8;
    localparam logic [FREQ_W-1:0] FREQ_SEED  = 5'd14;

    // reciprocal divide: exact floor(n / d) for 19-bit n with shift 24
    localparam int RCP_SHIFT = 24;
    localparam int RCP_W     = 22;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam int Q_W       = PROD_W - RCP_SHIFT;

    localparam logic [RCP_W-1:0] RCP_25 = 22'd671089;
    localparam logic [RCP_W-1:0] RCP_27 = 22'd621379;
    localparam logic [RCP_W-1:0] RCP_30 = 22'd559241;
    localparam logic [RCP_W-1:0] RCP_10 = 22'd1677722;
    localparam logic [RCP_W-1:0] RCP_8  = 22'd2097152;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_FREQ   = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic [SMP_W-1:0] wr_data;
        logic             clear;
    } t_ring_cmd;

    function automatic logic [RCP_W-1:0] recip(input logic [FREQ_W-1:0] f);
        logic [RCP_W-1:0] r;
        if (f < 5'd3) begin
            r = RCP_25;
        end else if (f < 5'd6) begin
            r = RCP_27;
        end else if (f < 5'd8) begin
            r = RCP_30;
        end else if (f < 5'd12) begin
            r = RCP_10;
        end else begin
            r = RCP_8;
        end
        return r;
    endfunction

endpackage

[design/nmsf_in_if.sv]
// Input channel of the noise moving-sum filter: valid/ready plus item payload.
// Depends on nmsf_pkg.
interface nmsf_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [nmsf_pkg::SMP_W-1:0] raw_sample;

    modport source (output valid, output kind, output raw_sample, input ready);
    modport sink   (input valid, input kind, input raw_sample, output ready);
endinterface

[design/nmsf_out_if.sv]
// Output channel of the noise moving-sum filter: valid/ready plus result payload.
// Depends on nmsf_pkg.
interface nmsf_out_if;
    logic                      valid;
    logic                      ready;
    logic                      dac1_write;
    logic [nmsf_pkg::SMP_W-1:0] dac1_value;
    logic                      dac1_random;
    logic                      dac2_reseed;
    logic [nmsf_pkg::SMP_W-1:0] filter_out;

    modport source (output valid, output dac1_write, output dac1_value,
                    output dac1_random, output dac2_reseed, output filter_out,
                    input ready);
    modport sink   (input valid, input dac1_write, input dac1_value,
                    input dac1_random, input dac2_reseed, input filter_out,
                    output ready);
endinterface

[design/nmsf_ring.sv]
// Sample ring: one-write/one-read synchronous memory with per-entry valid bits.
// Invalid entries read as zero; clear drops all valid bits. Depends on nmsf_pkg.
module nmsf_ring #(
    parameter int RING_DEPTH = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nmsf_pkg::t_ring_cmd               i_cmd,
    output logic signed [nmsf_pkg::SMP_W-1:0] o_rd_data
);
    localparam int AW = $clog2(RING_DEPTH);

    logic [nmsf_pkg::SMP_W-1:0] mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]      r_vld;
    logic [nmsf_pkg::SMP_W-1:0] r_rd_data;
    logic                       r_rd_vld;
    logic [AW-1:0]              wa;
    logic [AW-1:0]              ra;

    assign wa = i_cmd.wr_addr[AW-1:0];
    assign ra = i_cmd.rd_addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wa] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[ra];
            r_rd_vld  <= r_vld[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[wa] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? signed'(r_rd_data) : '0;

endmodule

[design/nmsf_scale.sv]
// Three-stage scaling unit: signed sum / divisor (toward zero) by reciprocal
// multiply, plus mid-scale offset and clip to 12 bits. Depends on nmsf_pkg.
module nmsf_scale (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [nmsf_pkg::SUM_W-1:0]  i_sum,
    input  logic [nmsf_pkg::FREQ_W-1:0]        i_freq,
    output logic                               o_done,
    output logic [nmsf_pkg::SMP_W-1:0]         o_value
);
    logic                          r_s1;
    logic                          r_s2;
    logic                          r_done;
    logic [nmsf_pkg::SUM_W-1:0]    r_abs;
    logic                          r_neg1;
    logic                          r_neg2;
    logic [nmsf_pkg::RCP_W-1:0]    r_rcp;
    logic [nmsf_pkg::PROD_W-1:0]   r_prod;
    logic [nmsf_pkg::SMP_W-1:0]    r_value;
    logic [nmsf_pkg::SUM_W-1:0]    n_abs;
    logic [nmsf_pkg::Q_W-1:0]      q;
    logic signed [nmsf_pkg::SUM_W-1:0] q_s;
    logic signed [nmsf_pkg::SUM_W-1:0] mid_s;
    logic signed [nmsf_pkg::SUM_W-1:0] n_y;
    logic [nmsf_pkg::SMP_W-1:0]    n_value;

    assign n_abs = i_sum[nmsf_pkg::SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    assign q     = r_prod[nmsf_pkg::RCP_SHIFT +: nmsf_pkg::Q_W];
    assign q_s   = signed'(nmsf_pkg::SUM_W'(q));
    assign mid_s = signed'(nmsf_pkg::SUM_W'(nmsf_pkg::MID));
    assign n_y   = r_neg2 ? (mid_s - q_s) : (mid_s + q_s);

    always_comb begin
        if (n_y < 0) begin
            n_value = '0;
        end else if (n_y > signed'(nmsf_pkg::SUM_W'(nmsf_pkg::TOP))) begin
            n_value = nmsf_pkg::TOP;
        end else begin
            n_value = n_y[nmsf_pkg::SMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_abs  <= n_abs;
            r_neg1 <= i_sum[nmsf_pkg::SUM_W-1];
            r_rcp  <= nmsf_pkg::recip(i_freq);
        end
        if (r_s1) begin
            r_prod <= nmsf_pkg::PROD_W'(r_abs) * nmsf_pkg::PROD_W'(r_rcp);
            r_neg2 <= r_neg1;
        end
        if (r_s2) begin
            r_value <= n_value;
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

[design/noise_moving_sum_filter_unit.sv]
// Noise moving-sum filter top level: control sequencer, running sum, output register.
// Depends on nmsf_pkg, nmsf_in_if, nmsf_out_if, nmsf_ring, nmsf_scale.
//
//   channel   dir  transfer when          payload
//   i_in      in   valid & ready          kind, raw_sample
//   o_out     out  valid & ready          dac1_write, dac1_value, dac1_random,
//                                         dac2_reseed, filter_out
//   i_cfg_*   in   i_cfg_we               index 0 noise_enable, 1 freq_index
//
// Sample ticks that filter go through ring read, sum update and write-back,
// then the three-stage reciprocal scaling unit. Other items go straight to output.
// One item is in flight at a time; the next is taken while a result waits.
// Synchronous active-low reset; ring entries read as zero until written.
module noise_moving_sum_filter_unit #(
    parameter int RING_DEPTH = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [nmsf_pkg::FREQ_W-1:0]       i_cfg_data,
    nmsf_in_if.sink                           i_in,
    nmsf_out_if.source                        o_out
);
    localparam int PW = nmsf_pkg::POS_W;
    localparam logic [PW:0] DEPTH_V = (PW+1)'(RING_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CALC = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    t_state                              r_state;
    logic                                r_enable;
    logic [nmsf_pkg::FREQ_W-1:0]         r_freq;
    logic signed [nmsf_pkg::SUM_W-1:0]   r_sum;
    logic [PW-1:0]                       r_pos;
    logic [nmsf_pkg::CNT_W-1:0]          r_cnt;
    logic [nmsf_pkg::SMP_W-1:0]          r_outv;
    logic signed [nmsf_pkg::SMP_W-1:0]   r_smp;
    logic [PW-1:0]                       r_wpos;
    logic                                r_start;
    logic                                r_res_wr;
    logic [nmsf_pkg::SMP_W-1:0]          r_res_val;
    logic                                r_res_rnd;
    logic                                r_res_rsd;
    logic                                r_o_valid;
    logic                                r_o_wr;
    logic [nmsf_pkg::SMP_W-1:0]          r_o_val;
    logic                                r_o_rnd;
    logic                                r_o_rsd;
    logic [nmsf_pkg::SMP_W-1:0]          r_o_filt;

    logic                                accept;
    logic                                slot_free;
    logic                                long_win;
    logic [PW-1:0]                       pos;
    logic [PW:0]                         pos_inc;
    logic [PW:0]                         win;
    logic [PW-1:0]                       nxt;
    logic [nmsf_pkg::CNT_W-1:0]          cnt_inc;
    logic                                seed_wrap;
    logic [nmsf_pkg::CNT_W-1:0]          n_cnt;
    logic signed [nmsf_pkg::SMP_W-1:0]   new_smp;
    logic signed [nmsf_pkg::SMP_W-1:0]   old_smp;
    logic signed [nmsf_pkg::SUM_W-1:0]   n_sum;
    logic                                filt_item;
    logic                                restart_item;
    nmsf_pkg::t_ring_cmd                 ring_cmd;
    logic                                scale_done;
    logic [nmsf_pkg::SMP_W-1:0]          scale_value;

    assign accept       = i_in.valid && (r_state == S_IDLE);
    assign slot_free    = !r_o_valid || o_out.ready;
    assign long_win     = r_freq < nmsf_pkg::FREQ_SHORT;
    assign pos          = ((PW+1)'(r_pos) < DEPTH_V) ? r_pos : '0;
    assign pos_inc      = (PW+1)'(pos) + 1'b1;
    assign win          = long_win ? DEPTH_V : nmsf_pkg::SHORT_WIN;
    assign nxt          = (pos_inc < win) ? pos_inc[PW-1:0] : '0;
    assign cnt_inc      = r_cnt + 1'b1;
    assign seed_wrap    = cnt_inc > nmsf_pkg::SEED_LIMIT;
    assign n_cnt        = seed_wrap ? '0 : cnt_inc;
    assign new_smp      = signed'({~i_in.raw_sample[nmsf_pkg::SMP_W-1],
                                   i_in.raw_sample[nmsf_pkg::SMP_W-2:0]});
    assign n_sum        = r_sum + nmsf_pkg::SUM_W'(r_smp) - nmsf_pkg::SUM_W'(old_smp);
    assign restart_item = r_enable && (i_in.kind == nmsf_pkg::KIND_RESTART);
    assign filt_item    = r_enable && (i_in.kind == nmsf_pkg::KIND_TICK)
                          && (r_freq < nmsf_pkg::FREQ_SEED);

    always_comb begin
        ring_cmd         = '0;
        ring_cmd.rd_en   = accept && filt_item;
        ring_cmd.rd_addr = nxt;
        ring_cmd.wr_en   = (r_state == S_RD);
        ring_cmd.wr_addr = r_wpos;
        ring_cmd.wr_data = r_smp;
        ring_cmd.clear   = accept && restart_item;
    end

    nmsf_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ring_cmd),
        .o_rd_data (old_smp)
    );

    nmsf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_sum   (r_sum),
        .i_freq  (r_freq),
        .o_done  (scale_done),
        .o_value (scale_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_freq   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nmsf_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                nmsf_pkg::CFG_FREQ:   r_freq   <= i_cfg_data;
                default:              r_freq   <= r_freq;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_outv    <= '0;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_start   <= (r_state == S_RD);
            r_o_valid <= ((r_state == S_PUT) && slot_free) || (r_o_valid && !o_out.ready);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (restart_item) begin
                            r_sum     <= '0;
                            r_pos     <= '0;
                            r_outv    <= nmsf_pkg::MID;
                            r_res_wr  <= 1'b0;
                            r_res_val <= '0;
                            r_res_rnd <= 1'b0;
                            r_res_rsd <= 1'b1;
                            r_state   <= S_PUT;
                        end else if (filt_item) begin
                            r_smp     <= new_smp;
                            r_wpos    <= pos;
                            r_pos     <= nxt;
                            r_res_wr  <= 1'b1;
                            r_res_val <= r_outv;
                            r_res_rnd <= 1'b0;
                            r_state   <= S_RD;
                            if (long_win) begin
                                r_res_rsd <= (pos_inc >= DEPTH_V);
                            end else begin
                                r_res_rsd <= seed_wrap;
                                r_cnt     <= n_cnt;
                            end
                        end else begin
                            r_res_wr  <= 1'b0;
                            r_res_val <= '0;
                            r_res_rsd <= 1'b0;
                            r_res_rnd <= r_enable && seed_wrap;
                            r_state   <= S_PUT;
                            if (r_enable) begin
                                r_cnt <= n_cnt;
                            end
                        end
                    end
                end
                S_RD: begin
                    r_sum   <= n_sum;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (scale_done) begin
                        r_outv  <= scale_value;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (slot_free) begin
                        r_o_wr    <= r_res_wr;
                        r_o_val   <= r_res_val;
                        r_o_rnd   <= r_res_rnd;
                        r_o_rsd   <= r_res_rsd;
                        r_o_filt  <= r_outv;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_o_valid;
    assign o_out.dac1_write  = r_o_wr;
    assign o_out.dac1_value  = r_o_val;
    assign o_out.dac1_random = r_o_rnd;
    assign o_out.dac2_reseed = r_o_rsd;
    assign o_out.filter_out  = r_o_filt;

endmodule

[tb/sv/tb.sv]
// Testbench for noise_moving_sum_filter_unit: directed and random noise sample streams
// checked field by field against an in-bench boxcar filter predictor.
// Depends on nmsf_pkg, nmsf_in_if, nmsf_out_if and the filter RTL.
module tb;

    localparam int DEPTH      = 100;
    localparam int SHORT_LEN  = 10;
    localparam int CENTER     = 2048;
    localparam int FULL_SCALE = 4095;
    localparam int WRAP_AT    = 17;
    localparam int IDX_SHORT  = 8;
    localparam int IDX_SEED   = 14;
    localparam int STALL_MAX  = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_PRINT  = 50;

    typedef struct packed {
        logic        kind;
        logic [11:0] raw;
    } t_noise_item;

    typedef struct packed {
        logic        dac1_write;
        logic [11:0] dac1_value;
        logic        dac1_random;
        logic        dac2_reseed;
        logic [11:0] filter_out;
    } t_dac_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [4:0] i_cfg_data;

    nmsf_in_if  in_ch ();
    nmsf_out_if out_ch ();

    noise_moving_sum_filter_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state
    logic signed [11:0] smp_hist [DEPTH];
    logic signed [18:0] acc_sum;
    logic [6:0]         wr_pos;
    logic [4:0]         seed_cnt;
    logic [11:0]        level;
    logic               cfg_en;
    logic [4:0]         cfg_freq;

    t_noise_item pend_items [$];
    t_dac_result dac_expect [$];

    int          src_idle_pct;
    int          snk_idle_pct;
    int          err_count;
    int          idle_cycles;
    int          hold_req;
    int          hold_ack;
    int          hold_left;
    logic        in_took;
    t_noise_item took_item;
    t_dac_result pred_res;
    t_dac_result got_res;
    t_dac_result want_res;

    function automatic bit seed_wrap();
        seed_cnt = seed_cnt + 5'd1;
        if (seed_cnt > WRAP_AT) begin
            seed_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_dac_result filter_step(input t_noise_item it);
        t_dac_result r;
        int          pos;
        int          nxt;
        int          win;
        int          divisor;
        int          y;
        int          s;
        bit          longwin;
        r = '0;
        if (cfg_en) begin
            if (it.kind == nmsf_pkg::KIND_RESTART) begin
                foreach (smp_hist[k]) smp_hist[k] = '0;
                acc_sum = '0;
                wr_pos = '0;
                level = 12'(CENTER);
                r.dac2_reseed = 1'b1;
            end else if (cfg_freq < IDX_SEED) begin
                longwin = cfg_freq < IDX_SHORT;
                win = longwin ? DEPTH : SHORT_LEN;
                pos = (wr_pos < DEPTH) ? int'(wr_pos) : 0;
                r.dac1_write = 1'b1;
                r.dac1_value = level;
                s = int'(it.raw) - CENTER;
                smp_hist[pos] = s[11:0];
                nxt = (pos + 1 < win) ? pos + 1 : 0;
                s = int'(acc_sum) + int'(smp_hist[pos]) - int'(smp_hist[nxt]);
                acc_sum = s[18:0];
                if (longwin) begin
                    r.dac2_reseed = (pos + 1 >= win);
                    divisor = (cfg_freq < 3) ? 25 : ((cfg_freq < 6) ? 27 : 30);
                end else begin
                    r.dac2_reseed = seed_wrap();
                    divisor = (cfg_freq < 12) ? 10 : 8;
                end
                y = int'(acc_sum) / divisor + CENTER;
                if (y < 0) y = 0;
                else if (y > FULL_SCALE) y = FULL_SCALE;
                level = y[11:0];
                wr_pos = nxt[6:0];
            end else begin
                r.dac1_random = seed_wrap();
            end
        end
        r.filter_out = level;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINT)
            $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // input side: acceptance and prediction at the rising edge
    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            took_item = pend_items.pop_front();
            pred_res = filter_step(took_item);
            dac_expect.push_back(pred_res);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_took) begin
            if (pend_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_ch.valid      <= 1'b1;
                in_ch.kind       <= pend_items[0].kind;
                in_ch.raw_sample <= pend_items[0].raw;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // output side: ready with random stalls and a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_res = {out_ch.dac1_write, out_ch.dac1_value, out_ch.dac1_random,
                       out_ch.dac2_reseed, out_ch.filter_out};
            if (dac_expect.size() == 0) begin
                report_mismatch("transfer with nothing pending, filter_out",
                                got_res.filter_out, -1);
            end else begin
                want_res = dac_expect.pop_front();
                if (got_res.dac1_write != want_res.dac1_write)
                    report_mismatch("dac1_write", got_res.dac1_write, want_res.dac1_write);
                if (got_res.dac1_value != want_res.dac1_value)
                    report_mismatch("dac1_value", got_res.dac1_value, want_res.dac1_value);
                if (got_res.dac1_random != want_res.dac1_random)
                    report_mismatch("dac1_random", got_res.dac1_random, want_res.dac1_random);
                if (got_res.dac2_reseed != want_res.dac2_reseed)
                    report_mismatch("dac2_reseed", got_res.dac2_reseed, want_res.dac2_reseed);
                if (got_res.filter_out != want_res.filter_out)
                    report_mismatch("filter_out", got_res.filter_out, want_res.filter_out);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("[noise_moving_sum_filter_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == nmsf_pkg::CFG_ENABLE)
            cfg_en = val[0];
        else
            cfg_freq = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(input logic en, input logic [4:0] freq);
        while (pend_items.size() != 0 || dac_expect.size() != 0) @(posedge i_clk);
        write_reg(nmsf_pkg::CFG_ENABLE, {4'd0, en});
        write_reg(nmsf_pkg::CFG_FREQ, freq);
        @(posedge i_clk);
    endtask

    task automatic push_item(input logic kind, input logic [11:0] raw);
        t_noise_item it;
        it.kind = kind;
        it.raw  = raw;
        pend_items.push_back(it);
    endtask

    function automatic logic [11:0] pick_sample(input int style);
        int v;
        case (style)
            1: v = ($urandom_range(9) == 0) ? $urandom_range(4095) : FULL_SCALE;
            2: v = ($urandom_range(9) == 0) ? $urandom_range(4095) : 0;
            3: v = $urandom_range(CENTER + 64, CENTER - 64);
            default: v = $urandom_range(4095);
        endcase
        return v[11:0];
    endfunction

    int          busy_items;
    int          phase_no;
    int          n_ticks;
    int          style;
    logic        en;
    logic [4:0]  freq;

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = nmsf_pkg::CFG_ENABLE;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = nmsf_pkg::KIND_TICK;
        in_ch.raw_sample = '0;
        out_ch.ready     = 1'b0;
        in_took          = 1'b0;
        err_count        = 0;
        idle_cycles      = 0;
        hold_req         = 0;
        hold_ack         = 0;
        hold_left        = 0;
        src_idle_pct     = 33;
        snk_idle_pct     = 68;
        foreach (smp_hist[k]) smp_hist[k] = '0;
        acc_sum  = '0;
        wr_pos   = '0;
        seed_cnt = '0;
        level    = '0;
        cfg_en   = 1'b0;
        cfg_freq = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: items pass with no effect
        push_item(nmsf_pkg::KIND_TICK, 12'hFFF);
        push_item(nmsf_pkg::KIND_RESTART, 12'h000);
        // long window, divide by 25, sample extremes
        setup(1'b1, 5'd0);
        push_item(nmsf_pkg::KIND_RESTART, 12'h123);
        push_item(nmsf_pkg::KIND_TICK, 12'h000);
        push_item(nmsf_pkg::KIND_TICK, 12'hFFF);
        push_item(nmsf_pkg::KIND_TICK, 12'h800);
        push_item(nmsf_pkg::KIND_TICK, 12'h7FF);
        // short window, divide by 8
        setup(1'b1, 5'd13);
        push_item(nmsf_pkg::KIND_TICK, 12'hFFF);
        push_item(nmsf_pkg::KIND_TICK, 12'h000);
        // reseed only, restart keeps the counter
        setup(1'b1, 5'd14);
        push_item(nmsf_pkg::KIND_TICK, 12'h555);
        push_item(nmsf_pkg::KIND_RESTART, 12'hAAA);
        push_item(nmsf_pkg::KIND_TICK, 12'h0F0);
        setup(1'b1, 5'd31);
        push_item(nmsf_pkg::KIND_TICK, 12'hFFF);
        // divide by 27 and 30, then short window entered past slot 9
        setup(1'b1, 5'd3);
        repeat (4) push_item(nmsf_pkg::KIND_TICK, 12'hF00);
        setup(1'b1, 5'd6);
        repeat (6) push_item(nmsf_pkg::KIND_TICK, 12'h0FF);
        setup(1'b1, 5'd9);
        push_item(nmsf_pkg::KIND_TICK, 12'hFFF);

        busy_items = 0;
        phase_no   = 0;
        while (busy_items < 900) begin
            phase_no++;
            en   = ($urandom_range(9) != 0);
            freq = ($urandom_range(4) == 0) ? 5'($urandom_range(31, 14))
                                            : 5'($urandom_range(13));
            setup(en, freq);
            if (busy_items < 300) begin
                src_idle_pct = 33;
                snk_idle_pct = 68;
            end else if (busy_items < 600) begin
                src_idle_pct = 68;
                snk_idle_pct = 33;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            n_ticks = ($urandom_range(4) == 0) ? $urandom_range(12, 1)
                                               : $urandom_range(140, 20);
            style = $urandom_range(4);
            if ($urandom_range(9) < 7)
                push_item(nmsf_pkg::KIND_RESTART, 12'($urandom_range(4095)));
            repeat (n_ticks) begin
                if ($urandom_range(99) < 3)
                    push_item(nmsf_pkg::KIND_RESTART, 12'($urandom_range(4095)));
                else
                    push_item(nmsf_pkg::KIND_TICK, pick_sample(style));
            end
            busy_items += n_ticks;
            if (phase_no == 3 || phase_no == 11)
                hold_req++;
        end

        while (pend_items.size() != 0 || dac_expect.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (dac_expect.size() != 0)
            report_mismatch("results still pending", 0, dac_expect.size());
        if (err_count == 0)
            $display("[noise_moving_sum_filter_unit] OK");
        else
            $display("[noise_moving_sum_filter_unit] ERROR");
        $finish;
    end

endmodule
